// ===== rtl/core/sads_pkg.sv =====
package sads_pkg;

  // Memory shape and field widths.
  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW         = $clog2(DEPTH + 1);
  localparam int SIZE_W     = 5;
  localparam int RESET_SIZE = (DEPTH < 16) ? DEPTH : 16;

  // Command codes.
  typedef enum logic [1:0] {
    CMD_PUSH      = 2'd0,
    CMD_POP       = 2'd1,
    CMD_DUMP_HIGH = 2'd2,
    CMD_DUMP_LOW  = 2'd3
  } cmd_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  // Side select: the lower stack grows up, the upper stack grows down.
  localparam logic SIDE_LOWER = 1'b1;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } state_t;

endpackage

// ===== rtl/core/sads_ram.sv =====
module sads_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/shared_array_double_stack.sv =====
// A push is taken when start is seen: the result strobes on the next cycle and busy stays low.
// Pop and dump read the shared RAM through its registered read port: an item that gives n
// results holds busy while it streams and strobes one result per cycle, the first after the RAM
// read and result registers. Push, empty dump and overflow results strobe in the cycle after start.
// Synchronous active-low reset empties both stacks and sets the size to its reset value; the
// RAM contents are not cleared. The receiver cannot stall, so each result shows for one cycle.
module shared_array_double_stack (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     in_command,
  input  logic                           in_side,
  input  logic signed [31:0]             in_push_value,
  input  logic                           cfg_we,
  input  logic [sads_pkg::SIZE_W-1:0]    cfg_active_size,
  output logic                           out_strobe,
  output logic signed [31:0]             out_data_out,
  output logic [1:0]                     out_status,
  output logic                           out_last
);

  import sads_pkg::*;

  state_t                state_r, state_nxt;
  logic [CW-1:0]         size_r, size_nxt;
  logic [CW-1:0]         lo_cnt_r, lo_cnt_nxt;
  logic [CW-1:0]         up_cnt_r, up_cnt_nxt;
  logic [CW-1:0]         left_r, left_nxt;
  logic [AW-1:0]         rd_addr_r, rd_addr_nxt;
  logic                  strobe_r, strobe_nxt;
  logic [31:0]           data_r, data_nxt;
  status_t               status_r, status_nxt;
  logic                  last_r, last_nxt;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [AW-1:0]         ram_raddr;
  logic [DATA_WIDTH-1:0] ram_rdata;

  logic [CW:0]           cnt_sum;
  logic                  full;
  logic                  dump_lower;
  logic [CW-1:0]         dump_n;
  logic [CW-1:0]         up_base;
  logic [CW-1:0]         cfg_size;

  sads_ram #(
    .WIDTH(DATA_WIDTH),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(in_push_value),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Fill level and the first entry of the upper stack.
  assign cnt_sum = {1'b0, lo_cnt_r} + {1'b0, up_cnt_r};
  assign full    = cnt_sum >= {1'b0, size_r};
  assign up_base = size_r - up_cnt_r;

  // Pick the stack to dump; a tie picks the lower stack for both commands.
  always_comb begin
    if (in_command == CMD_DUMP_HIGH) begin
      dump_lower = !(lo_cnt_r < up_cnt_r);
    end else begin
      dump_lower = !(lo_cnt_r > up_cnt_r);
    end
    dump_n = dump_lower ? lo_cnt_r : up_cnt_r;
  end

  // Saturate the written size into the range one to DEPTH.
  always_comb begin
    if (cfg_active_size == '0) begin
      cfg_size = CW'(1);
    end else if (int'(cfg_active_size) > DEPTH) begin
      cfg_size = CW'(DEPTH);
    end else begin
      cfg_size = CW'(cfg_active_size);
    end
  end

  // Command sequencer: a size write empties both stacks, push writes at once, pop and dump stream reads.
  always_comb begin
    state_nxt   = state_r;
    size_nxt    = size_r;
    lo_cnt_nxt  = lo_cnt_r;
    up_cnt_nxt  = up_cnt_r;
    left_nxt    = left_r;
    rd_addr_nxt = rd_addr_r;
    strobe_nxt  = 1'b0;
    data_nxt    = '0;
    status_nxt  = ST_OK;
    last_nxt    = 1'b1;
    ram_we      = 1'b0;
    ram_waddr   = lo_cnt_r[AW-1:0];
    ram_raddr   = rd_addr_r;

    case (state_r)
      S_IDLE: begin
        if (cfg_we) begin
          size_nxt   = cfg_size;
          lo_cnt_nxt = '0;
          up_cnt_nxt = '0;
        end else if (start) begin
          case (in_command)
            CMD_PUSH: begin
              strobe_nxt = 1'b1;
              if (full) begin
                status_nxt = ST_OVERFLOW;
              end else if (in_side == SIDE_LOWER) begin
                ram_we     = 1'b1;
                ram_waddr  = lo_cnt_r[AW-1:0];
                lo_cnt_nxt = lo_cnt_r + 1'b1;
              end else begin
                ram_we     = 1'b1;
                ram_waddr  = AW'(up_base - 1'b1);
                up_cnt_nxt = up_cnt_r + 1'b1;
              end
            end
            CMD_POP: begin
              if (in_side == SIDE_LOWER) begin
                if (lo_cnt_r == '0) begin
                  strobe_nxt = 1'b1;
                  status_nxt = ST_UNDERFLOW;
                end else begin
                  ram_raddr   = AW'(lo_cnt_r - 1'b1);
                  lo_cnt_nxt  = lo_cnt_r - 1'b1;
                  left_nxt    = CW'(1);
                  rd_addr_nxt = ram_raddr + 1'b1;
                  state_nxt   = S_READ;
                end
              end else begin
                if (up_cnt_r == '0) begin
                  strobe_nxt = 1'b1;
                  status_nxt = ST_UNDERFLOW;
                end else begin
                  ram_raddr   = AW'(up_base);
                  up_cnt_nxt  = up_cnt_r - 1'b1;
                  left_nxt    = CW'(1);
                  rd_addr_nxt = ram_raddr + 1'b1;
                  state_nxt   = S_READ;
                end
              end
            end
            default: begin
              // Both dumps read upward: the lower stack from its base, the upper stack from its top entry.
              if (dump_n == '0) begin
                strobe_nxt = 1'b1;
                status_nxt = ST_EMPTY;
              end else begin
                ram_raddr   = dump_lower ? '0 : AW'(up_base);
                left_nxt    = dump_n;
                rd_addr_nxt = ram_raddr + 1'b1;
                state_nxt   = S_READ;
              end
            end
          endcase
        end
      end
      S_READ: begin
        // Read data from the previous cycle becomes a result; the next read goes out.
        strobe_nxt  = 1'b1;
        data_nxt    = ram_rdata;
        last_nxt    = (left_r == CW'(1));
        left_nxt    = left_r - 1'b1;
        rd_addr_nxt = rd_addr_r + 1'b1;
        if (left_r == CW'(1)) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      size_r   <= CW'(RESET_SIZE);
      lo_cnt_r <= '0;
      up_cnt_r <= '0;
      left_r   <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      size_r   <= size_nxt;
      lo_cnt_r <= lo_cnt_nxt;
      up_cnt_r <= up_cnt_nxt;
      left_r   <= left_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  // Result payload and read pointer.
  always_ff @(posedge clk) begin
    rd_addr_r <= rd_addr_nxt;
    data_r    <= data_nxt;
    status_r  <= status_nxt;
    last_r    <= last_nxt;
  end

  assign busy         = (state_r != S_IDLE);
  assign out_strobe   = strobe_r;
  assign out_data_out = data_r;
  assign out_status   = status_r;
  assign out_last     = last_r;

`ifndef SYNTHESIS
  // The two stacks never hold more words than the active size.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_sum <= {1'b0, size_r})
    else $error("stacks overlap");

  // Status results other than ok always close the transfer.
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && (out_status != ST_OK) |-> out_last)
    else $error("non-ok result without last");

  // A push gives its single result on the next cycle.
  a_push_result: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && !cfg_we && (in_command == CMD_PUSH) |=> out_strobe && out_last)
    else $error("push result missing");
`endif

endmodule
